// ===== hw/rtl/mgb_pkg.sv =====
// ----------------------------------------------------------------------------
// mgb_pkg
// Shared types and constants of the modal gap buffer line editor: field
// widths, request and key codes, controller states, command and status words.
// ----------------------------------------------------------------------------
package mgb_pkg;

	// Total number of characters that both stacks hold together.
	localparam int CAPACITY = 256;
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	// Widths of the word fields.
	localparam int CHAR_W = 8;
	localparam int IDX_W  = 9;
	localparam int POS_W  = 9;

	// Width wide enough to compare a read index against the stack counts.
	localparam int CMP_W = ((IDX_W > CNT_W) ? IDX_W : CNT_W) + 1;

	// Key codes with a meaning of their own.
	localparam logic [CHAR_W-1:0] KEY_NONE      = 8'd0;
	localparam logic [CHAR_W-1:0] KEY_BACKSPACE = 8'd127;
	localparam logic [CHAR_W-1:0] KEY_IGNORED   = 8'd126;
	localparam logic [CHAR_W-1:0] KEY_APPEND    = 8'd97;
	localparam logic [CHAR_W-1:0] KEY_QUIT      = 8'd113;
	localparam logic [CHAR_W-1:0] KEY_CUT       = 8'd120;
	localparam logic [CHAR_W-1:0] KEY_CUT_PREV  = 8'd105;
	localparam logic [CHAR_W-1:0] KEY_REPLACE   = 8'd114;

	// Request codes.
	typedef enum logic [2:0] {
		REQ_KEY     = 3'd0,
		REQ_RIGHT   = 3'd1,
		REQ_LEFT    = 3'd2,
		REQ_END     = 3'd3,
		REQ_BEGIN   = 3'd4,
		REQ_FWD_DEL = 3'd5,
		REQ_ESCAPE  = 3'd6,
		REQ_READ    = 3'd7
	} req_t;

	// Controller states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_FETCH,
		ST_MOVE,
		ST_FINISH
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic decode;
		logic fetch;
		logic move_step;
		logic finish;
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic need_fetch;
		logic need_move;
		logic move_done;
	} dp_status_t;

	// One result word.
	typedef struct packed {
		logic              in_read_mode;
		logic              replace_armed;
		logic              done_res;
		logic [POS_W-1:0]  cursor_pos;
		logic [POS_W-1:0]  text_length;
		logic [CHAR_W-1:0] read_char;
		logic              read_valid;
		logic              overflow;
	} rsp_t;

endpackage

// ===== hw/rtl/mgb_req_if.sv =====
// ----------------------------------------------------------------------------
// mgb_req_if
// Request channel: one word per editor request, valid/ready handshake.
// ----------------------------------------------------------------------------
interface mgb_req_if;
	import mgb_pkg::*;

	logic                 valid;
	logic                 ready;
	req_t                 req_type;
	logic [CHAR_W-1:0]    key_char;
	logic [IDX_W-1:0]     read_index;

	modport source (output valid, req_type, key_char, read_index, input ready);
	modport sink   (input valid, req_type, key_char, read_index, output ready);

endinterface

// ===== hw/rtl/mgb_rsp_if.sv =====
// ----------------------------------------------------------------------------
// mgb_rsp_if
// Result channel: one word per accepted request, valid/ready handshake.
// ----------------------------------------------------------------------------
interface mgb_rsp_if;
	import mgb_pkg::*;

	logic              valid;
	logic              ready;
	logic              in_read_mode;
	logic              replace_armed;
	logic              done_res;
	logic [POS_W-1:0]  cursor_pos;
	logic [POS_W-1:0]  text_length;
	logic [CHAR_W-1:0] read_char;
	logic              read_valid;
	logic              overflow;

	modport source (
		output valid, in_read_mode, replace_armed, done_res, cursor_pos,
		output text_length, read_char, read_valid, overflow,
		input  ready
	);
	modport sink (
		input  valid, in_read_mode, replace_armed, done_res, cursor_pos,
		input  text_length, read_char, read_valid, overflow,
		output ready
	);

endinterface

// ===== hw/rtl/modal_gap_buffer_line_editor.sv =====
// ----------------------------------------------------------------------------
// modal_gap_buffer_line_editor
// One-line text editor with read and edit modes, held as a gap buffer.
// ----------------------------------------------------------------------------
// The text lives in two stack memories, the characters before the cursor and
// those after it, which share CAPACITY characters; every accepted request word
// gives exactly one result word with the mode flags, cursor, length and, for
// read requests, the character at the requested position. Requests are taken
// one at a time. Each request is captured, decoded and then finished, the
// finish step loading the result register. A read inside the text passes
// through a fetch step before finish, and so, before a quit, does a
// cut-previous command with no pending replacement and at least two
// characters before the cursor; before a quit, a cursor step or a move to
// the end or the beginning passes through the move step, where the move
// engine carries one character per cycle through the single read port of
// one stack and the write port of the other. The controller returns to idle
// as the result is loaded, and loading waits for as long as an earlier
// result word is still held on the output side. A new request is taken
// while the previous result still waits on the output side. Stack memories
// need no clearing after reset; the block is ready at once.
module modal_gap_buffer_line_editor (
	input  logic       clk,
	input  logic       arst_n,
	mgb_req_if.sink    req,
	mgb_rsp_if.source  rsp
);
	import mgb_pkg::*;

	ctrl_cmd_t  cmd;
	dp_status_t status;
	rsp_t       rsp_word;

	// Sequencing.
	mgb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.status    (status),
		.cmd       (cmd)
	);

	// Stacks, counters, flags and result register.
	mgb_dpath u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_type   (req.req_type),
		.key_char   (req.key_char),
		.read_index (req.read_index),
		.cmd        (cmd),
		.status     (status),
		.rsp        (rsp_word)
	);

	// Result word onto the output channel.
	assign rsp.in_read_mode  = rsp_word.in_read_mode;
	assign rsp.replace_armed = rsp_word.replace_armed;
	assign rsp.done_res      = rsp_word.done_res;
	assign rsp.cursor_pos    = rsp_word.cursor_pos;
	assign rsp.text_length   = rsp_word.text_length;
	assign rsp.read_char     = rsp_word.read_char;
	assign rsp.read_valid    = rsp_word.read_valid;
	assign rsp.overflow      = rsp_word.overflow;

endmodule

// ===== hw/rtl/mgb_ctrl.sv =====
// ----------------------------------------------------------------------------
// mgb_ctrl
// Controller of the line editor: sequences capture, decode, memory fetch,
// character moves and the result register, and owns the result valid flag.
// ----------------------------------------------------------------------------
module mgb_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	input  mgb_pkg::dp_status_t status,
	output mgb_pkg::ctrl_cmd_t  cmd
);
	import mgb_pkg::*;

	state_t state_q;
	state_t state_nxt;
	logic   rsp_valid_q;
	logic   rsp_free;

	// The result register can take a new word when empty or being drained.
	assign rsp_free = !rsp_valid_q || rsp_ready;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state.
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					state_nxt = ST_DECODE;
				end
			end
			ST_DECODE: begin
				if (status.need_fetch) begin
					state_nxt = ST_FETCH;
				end else if (status.need_move) begin
					state_nxt = ST_MOVE;
				end else begin
					state_nxt = ST_FINISH;
				end
			end
			ST_FETCH: begin
				state_nxt = ST_FINISH;
			end
			ST_MOVE: begin
				if (status.move_done) begin
					state_nxt = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (rsp_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// Commands to the datapath.
	always_comb begin
		cmd           = '0;
		req_ready     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req_ready   = 1'b1;
				cmd.capture = req_valid;
			end
			ST_DECODE: begin
				cmd.decode = 1'b1;
			end
			ST_FETCH: begin
				cmd.fetch = 1'b1;
			end
			ST_MOVE: begin
				cmd.move_step = 1'b1;
			end
			ST_FINISH: begin
				cmd.finish = rsp_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	// Result valid flag: set when a word is loaded, cleared when taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = rsp_valid_q;

endmodule

// ===== hw/rtl/mgb_dpath.sv =====
// ----------------------------------------------------------------------------
// mgb_dpath
// Datapath of the line editor: the two stack memories, their counts, the mode
// flags, the character move engine and the result register.
// ----------------------------------------------------------------------------
module mgb_dpath (
	input  logic                       clk,
	input  logic                       arst_n,
	input  mgb_pkg::req_t              req_type,
	input  logic [mgb_pkg::CHAR_W-1:0] key_char,
	input  logic [mgb_pkg::IDX_W-1:0]  read_index,
	input  mgb_pkg::ctrl_cmd_t         cmd,
	output mgb_pkg::dp_status_t        status,
	output mgb_pkg::rsp_t              rsp
);
	import mgb_pkg::*;

	localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
	localparam logic [CNT_W-1:0] CNT_TWO = CNT_W'(2);
	localparam logic [CNT_W:0]   CAP_SUM = (CNT_W + 1)'(CAPACITY);

	// Captured request.
	req_t              req_type_q;
	logic [CHAR_W-1:0] key_q;
	logic [IDX_W-1:0]  idx_q;

	// Editor state.
	logic [CNT_W-1:0] fc_q, fc_nxt;
	logic [CNT_W-1:0] bc_q, bc_nxt;
	logic             mode_q, mode_nxt;
	logic             rep_q, rep_nxt;
	logic             quit_q, quit_nxt;

	// Per-request result fields.
	logic [CHAR_W-1:0] ch_q, ch_nxt;
	logic              valid_q, valid_nxt;
	logic              drop_q, drop_nxt;
	logic              rd_back_q, rd_back_nxt;

	// Move engine.
	logic             pend_q, pend_nxt;
	logic             issued_q, issued_nxt;
	logic             dir_q, dir_nxt;
	logic             multi_q, multi_nxt;
	logic [CNT_W-1:0] src_cnt;
	logic             can_issue;

	// Stack memories and their ports.
	logic [CHAR_W-1:0] front_mem [CAPACITY];
	logic [CHAR_W-1:0] back_mem  [CAPACITY];
	logic              front_we, front_re, back_we, back_re;
	logic [ADDR_W-1:0] front_wa, front_ra, back_wa, back_ra;
	logic [CHAR_W-1:0] front_wd, back_wd;
	logic [CHAR_W-1:0] front_rd_q, back_rd_q;

	// Read request address math.
	logic [CMP_W-1:0] idx_x, fc_x, bc_x, back_off;
	logic             idx_hit, idx_front;
	logic [CNT_W:0]   total;

	// Read-mode key decode.
	logic replaced, i_copy;

	rsp_t rsp_q;

	assign total     = {1'b0, fc_q} + {1'b0, bc_q};
	assign idx_x     = CMP_W'(idx_q);
	assign fc_x      = CMP_W'(fc_q);
	assign bc_x      = CMP_W'(bc_q);
	assign idx_hit   = idx_x < (fc_x + bc_x);
	assign idx_front = idx_x < fc_x;
	// Back stack is stored top-last: text position maps to bc-1-(idx-fc).
	assign back_off  = bc_x - CMP_W'(1) - (idx_x - fc_x);

	assign replaced  = rep_q && (fc_q != '0) && (key_q != KEY_BACKSPACE);
	assign i_copy    = (key_q == KEY_CUT_PREV) && (fc_q >= CNT_TWO);

	// The move engine drains the source stack one character per cycle.
	assign src_cnt   = dir_q ? bc_q : fc_q;
	assign can_issue = (src_cnt != '0) && (multi_q || !issued_q);

	// Next-state and memory port logic for all commands.
	always_comb begin
		fc_nxt      = fc_q;
		bc_nxt      = bc_q;
		mode_nxt    = mode_q;
		rep_nxt     = rep_q;
		quit_nxt    = quit_q;
		ch_nxt      = ch_q;
		valid_nxt   = valid_q;
		drop_nxt    = drop_q;
		rd_back_nxt = rd_back_q;
		pend_nxt    = pend_q;
		issued_nxt  = issued_q;
		dir_nxt     = dir_q;
		multi_nxt   = multi_q;
		front_we    = 1'b0;
		front_wa    = ADDR_W'(fc_q);
		front_wd    = key_q;
		front_re    = 1'b0;
		front_ra    = ADDR_W'(fc_q - CNT_ONE);
		back_we     = 1'b0;
		back_wa     = ADDR_W'(bc_q);
		back_wd     = front_rd_q;
		back_re     = 1'b0;
		back_ra     = ADDR_W'(bc_q - CNT_ONE);
		status      = '0;

		// Clear the per-request fields as a new word comes in.
		if (cmd.capture) begin
			ch_nxt    = '0;
			valid_nxt = 1'b0;
			drop_nxt  = 1'b0;
		end

		// Decode: apply a request's effects directly, or start a fetch or a move.
		if (cmd.decode) begin
			if (req_type_q == REQ_READ) begin
				valid_nxt         = idx_hit;
				status.need_fetch = idx_hit;
				rd_back_nxt       = !idx_front;
				front_re          = idx_hit && idx_front;
				front_ra          = ADDR_W'(idx_q);
				back_re           = idx_hit && !idx_front;
				back_ra           = ADDR_W'(back_off);
			end else if (!quit_q) begin
				case (req_type_q)
					REQ_KEY: begin
						if (key_q == KEY_NONE) begin
							fc_nxt = fc_q;
						end else if (!mode_q) begin
							// Edit mode: backspace, ignored key or insert.
							if (key_q == KEY_BACKSPACE) begin
								if (fc_q != '0) begin
									fc_nxt = fc_q - CNT_ONE;
								end
							end else if (key_q != KEY_IGNORED) begin
								if (total >= CAP_SUM) begin
									drop_nxt = 1'b1;
								end else begin
									front_we = 1'b1;
									fc_nxt   = fc_q + CNT_ONE;
								end
							end
						end else begin
							// Read mode: a pending replacement comes first.
							if (replaced) begin
								rep_nxt  = 1'b0;
								front_we = 1'b1;
								front_wa = i_copy ? ADDR_W'(fc_q - CNT_TWO)
								                  : ADDR_W'(fc_q - CNT_ONE);
							end
							if (key_q == KEY_APPEND) begin
								mode_nxt = 1'b0;
							end else if (key_q == KEY_QUIT) begin
								quit_nxt = 1'b1;
							end else if (key_q == KEY_CUT) begin
								if (fc_q != '0) begin
									fc_nxt = fc_q - CNT_ONE;
								end
							end else if (key_q == KEY_CUT_PREV) begin
								// The top character slides down over the one below.
								if (i_copy && !replaced) begin
									status.need_fetch = 1'b1;
									front_re          = 1'b1;
									rd_back_nxt       = 1'b0;
								end else if (i_copy) begin
									fc_nxt = fc_q - CNT_ONE;
								end
							end else if (key_q == KEY_REPLACE) begin
								if (!replaced) begin
									rep_nxt = 1'b1;
								end
							end
						end
					end
					REQ_RIGHT, REQ_LEFT, REQ_END, REQ_BEGIN: begin
						status.need_move = 1'b1;
						dir_nxt    = (req_type_q == REQ_RIGHT) || (req_type_q == REQ_END);
						multi_nxt  = (req_type_q == REQ_END) || (req_type_q == REQ_BEGIN);
						issued_nxt = 1'b0;
						pend_nxt   = 1'b0;
					end
					REQ_FWD_DEL: begin
						if (!mode_q && (bc_q != '0)) begin
							bc_nxt = bc_q - CNT_ONE;
						end
					end
					REQ_ESCAPE: begin
						mode_nxt = 1'b1;
					end
					default: begin
						mode_nxt = mode_q;
					end
				endcase
			end
		end

		// Fetch: finish a read request or the cut-previous copy.
		if (cmd.fetch) begin
			if (req_type_q == REQ_READ) begin
				ch_nxt = rd_back_q ? back_rd_q : front_rd_q;
			end else begin
				front_we = 1'b1;
				front_wa = ADDR_W'(fc_q - CNT_TWO);
				front_wd = front_rd_q;
				fc_nxt   = fc_q - CNT_ONE;
			end
		end

		// Move step: write the character read last cycle, read the next one.
		if (cmd.move_step) begin
			status.move_done = !can_issue;
			if (pend_q) begin
				if (dir_q) begin
					front_we = 1'b1;
					front_wa = ADDR_W'(fc_q);
					front_wd = back_rd_q;
					fc_nxt   = fc_q + CNT_ONE;
				end else begin
					back_we = 1'b1;
					back_wa = ADDR_W'(bc_q);
					back_wd = front_rd_q;
					bc_nxt  = bc_q + CNT_ONE;
				end
			end
			if (can_issue) begin
				if (dir_q) begin
					back_re = 1'b1;
					bc_nxt  = bc_q - CNT_ONE;
				end else begin
					front_re = 1'b1;
					fc_nxt   = fc_q - CNT_ONE;
				end
			end
			pend_nxt   = can_issue;
			issued_nxt = issued_q | can_issue;
		end
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fc_q     <= '0;
			bc_q     <= '0;
			mode_q   <= 1'b1;
			rep_q    <= 1'b0;
			quit_q   <= 1'b0;
			pend_q   <= 1'b0;
			issued_q <= 1'b0;
		end else begin
			fc_q     <= fc_nxt;
			bc_q     <= bc_nxt;
			mode_q   <= mode_nxt;
			rep_q    <= rep_nxt;
			quit_q   <= quit_nxt;
			pend_q   <= pend_nxt;
			issued_q <= issued_nxt;
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_type_q <= req_type;
			key_q      <= key_char;
			idx_q      <= read_index;
		end
		ch_q      <= ch_nxt;
		valid_q   <= valid_nxt;
		drop_q    <= drop_nxt;
		rd_back_q <= rd_back_nxt;
		dir_q     <= dir_nxt;
		multi_q   <= multi_nxt;
	end

	// Front stack memory: one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (front_we) begin
			front_mem[front_wa] <= front_wd;
		end
		if (front_re) begin
			front_rd_q <= front_mem[front_ra];
		end
	end

	// Back stack memory: one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (back_we) begin
			back_mem[back_wa] <= back_wd;
		end
		if (back_re) begin
			back_rd_q <= back_mem[back_ra];
		end
	end

	// Result register, loaded once the request has settled.
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			rsp_q.in_read_mode  <= mode_q;
			rsp_q.replace_armed <= rep_q;
			rsp_q.done_res      <= quit_q;
			rsp_q.cursor_pos    <= POS_W'(fc_q);
			rsp_q.text_length   <= POS_W'(total);
			rsp_q.read_char     <= ch_q;
			rsp_q.read_valid    <= valid_q;
			rsp_q.overflow      <= drop_q;
		end
	end

	assign rsp = rsp_q;

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the modal gap buffer line editor. Directed tests
// cover edit keys, read-mode commands, a full buffer and quit; a weighted
// random mix under several idling patterns runs before the quit test. Every
// status word is checked field by field against an in-bench copy of the editor state.
// ----------------------------------------------------------------------------
module testbench;
	import mgb_pkg::*;

	logic clk;
	logic arst_n;

	mgb_req_if req_ch ();
	mgb_rsp_if rsp_ch ();

	modal_gap_buffer_line_editor dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// Editor state as the bench tracks it: text before and after the cursor.
	logic [CHAR_W-1:0] head_chars [CAPACITY];
	logic [CHAR_W-1:0] tail_chars [CAPACITY];
	int head_n = 0;
	int tail_n = 0;
	bit cmd_mode = 1'b1;
	bit armed = 1'b0;
	bit quit_done = 1'b0;

	// Status words still to come back, oldest first.
	rsp_t status_queue [$];
	rsp_t oldest_status;

	int idle_pct = 0;
	int stall_pct = 0;
	int error_count = 0;

	// Clock.
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Watchdog: ends a run that hangs.
	initial begin
		#60_000_000;
		$display("simulation failed");
		$finish;
	end

	task automatic report_mismatch(string what, int got, int want);
		error_count++;
		if (error_count <= 40)
			$display("MISMATCH at %0t ns: %s got %0d want %0d", $time, what, got, want);
	endtask

	task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
		if (got !== want)
			report_mismatch(name, int'(got), int'(want));
	endtask

	// Cursor steps: one character moves between the two stacks.
	function automatic void step_left();
		if (head_n > 0 && tail_n < CAPACITY) begin
			head_n--;
			tail_chars[tail_n] = head_chars[head_n];
			tail_n++;
		end
	endfunction

	function automatic void step_right();
		if (tail_n > 0 && head_n < CAPACITY) begin
			tail_n--;
			head_chars[head_n] = tail_chars[tail_n];
			head_n++;
		end
	endfunction

	// One key in the current mode; returns 1 when an insert was dropped.
	function automatic bit press_key(logic [CHAR_W-1:0] k);
		bit replaced;
		replaced = 1'b0;
		if (k == KEY_NONE)
			return 1'b0;
		if (!cmd_mode) begin
			if (k == KEY_BACKSPACE) begin
				if (head_n > 0)
					head_n--;
			end else if (k != KEY_IGNORED) begin
				if (head_n + tail_n >= CAPACITY)
					return 1'b1;
				head_chars[head_n] = k;
				head_n++;
			end
			return 1'b0;
		end
		// A pending replacement takes the key before it acts as a command.
		if (armed && head_n > 0 && k != KEY_BACKSPACE) begin
			head_chars[head_n-1] = k;
			armed = 1'b0;
			replaced = 1'b1;
		end
		case (k)
			KEY_APPEND: cmd_mode = 1'b0;
			KEY_QUIT: quit_done = 1'b1;
			KEY_CUT: begin
				if (head_n > 0)
					head_n--;
			end
			KEY_CUT_PREV: begin
				if (head_n >= 2) begin
					head_chars[head_n-2] = head_chars[head_n-1];
					head_n--;
				end
			end
			KEY_REPLACE: begin
				if (!replaced)
					armed = 1'b1;
			end
			default: ;
		endcase
		return 1'b0;
	endfunction

	// Applies one request word to the tracked state and returns its status word.
	function automatic rsp_t apply_request(req_t t, logic [CHAR_W-1:0] k,
			logic [IDX_W-1:0] idx);
		rsp_t r;
		int pos;
		r = '0;
		pos = int'(idx);
		if (t == REQ_READ) begin
			if (pos < head_n) begin
				r.read_valid = 1'b1;
				r.read_char = head_chars[pos];
			end else if (pos - head_n < tail_n) begin
				r.read_valid = 1'b1;
				r.read_char = tail_chars[tail_n - 1 - (pos - head_n)];
			end
		end else if (!quit_done) begin
			case (t)
				REQ_KEY: r.overflow = press_key(k);
				REQ_RIGHT: step_right();
				REQ_LEFT: step_left();
				REQ_END: while (tail_n > 0) step_right();
				REQ_BEGIN: while (head_n > 0) step_left();
				REQ_FWD_DEL: begin
					if (!cmd_mode && tail_n > 0)
						tail_n--;
				end
				default: cmd_mode = 1'b1;
			endcase
		end
		r.in_read_mode = cmd_mode;
		r.replace_armed = armed;
		r.done_res = quit_done;
		r.cursor_pos = POS_W'(head_n);
		r.text_length = POS_W'(head_n + tail_n);
		return r;
	endfunction

	// Sends one request word; the status is worked out when it is accepted.
	task automatic send_word(req_t t, logic [CHAR_W-1:0] k, logic [IDX_W-1:0] idx);
		while ($urandom_range(99) < idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.req_type <= t;
		req_ch.key_char <= k;
		req_ch.read_index <= idx;
		do @(posedge clk); while (!req_ch.ready);
		status_queue.push_back(apply_request(t, k, idx));
	endtask

	task automatic type_key(logic [CHAR_W-1:0] k);
		send_word(REQ_KEY, k, IDX_W'($urandom_range(511)));
	endtask

	task automatic do_req(req_t t);
		send_word(t, CHAR_W'($urandom_range(255)), IDX_W'($urandom_range(511)));
	endtask

	task automatic read_at(logic [IDX_W-1:0] idx);
		send_word(REQ_READ, CHAR_W'($urandom_range(255)), idx);
	endtask

	task automatic set_idling(int idle, int stall);
		idle_pct = idle;
		stall_pct = stall;
	endtask

	// Result side: check each accepted word, then pick the next ready value.
	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (status_queue.size() == 0) begin
				report_mismatch("status word with none awaited", 0, 0);
			end else begin
				oldest_status = status_queue.pop_front();
				check_field("in_read_mode", 16'(rsp_ch.in_read_mode),
					16'(oldest_status.in_read_mode));
				check_field("replace_armed", 16'(rsp_ch.replace_armed),
					16'(oldest_status.replace_armed));
				check_field("done_res", 16'(rsp_ch.done_res), 16'(oldest_status.done_res));
				check_field("cursor_pos", 16'(rsp_ch.cursor_pos),
					16'(oldest_status.cursor_pos));
				check_field("text_length", 16'(rsp_ch.text_length),
					16'(oldest_status.text_length));
				check_field("read_char", 16'(rsp_ch.read_char),
					16'(oldest_status.read_char));
				check_field("read_valid", 16'(rsp_ch.read_valid),
					16'(oldest_status.read_valid));
				check_field("overflow", 16'(rsp_ch.overflow), 16'(oldest_status.overflow));
			end
		end
		rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
	end

	// Edit-mode keys, cursor moves and forward delete from an empty buffer.
	task automatic test_edit_keys();
		read_at(9'd0);
		read_at(9'd511);
		type_key(KEY_CUT);
		type_key(KEY_APPEND);
		type_key(KEY_BACKSPACE);
		type_key(KEY_NONE);
		type_key(KEY_IGNORED);
		type_key(8'd255);
		type_key(8'd1);
		type_key(KEY_QUIT);
		type_key(8'h68);
		do_req(REQ_LEFT);
		do_req(REQ_LEFT);
		do_req(REQ_FWD_DEL);
		do_req(REQ_RIGHT);
		do_req(REQ_BEGIN);
		do_req(REQ_LEFT);
		do_req(REQ_FWD_DEL);
		do_req(REQ_END);
		do_req(REQ_RIGHT);
		do_req(REQ_FWD_DEL);
		read_at(9'd0);
		read_at(9'd1);
		read_at(9'd2);
	endtask

	// Read-mode commands: cuts, one-shot replacement and its corner cases.
	task automatic test_read_commands();
		do_req(REQ_ESCAPE);
		type_key(KEY_REPLACE);
		do_req(REQ_ESCAPE);
		type_key(8'h7a);
		type_key(KEY_REPLACE);
		type_key(KEY_REPLACE);
		type_key(KEY_REPLACE);
		type_key(KEY_BACKSPACE);
		type_key(KEY_CUT);
		type_key(KEY_APPEND);
		type_key(8'h6b);
		type_key(8'h6c);
		type_key(8'h6d);
		do_req(REQ_ESCAPE);
		do_req(REQ_FWD_DEL);
		type_key(KEY_CUT_PREV);
		do_req(REQ_BEGIN);
		type_key(KEY_CUT_PREV);
		do_req(REQ_RIGHT);
		type_key(KEY_CUT_PREV);
		type_key(KEY_CUT);
		type_key(KEY_REPLACE);
		type_key(8'h6e);
		do_req(REQ_END);
		read_at(9'd0);
	endtask

	// Fills the buffer to capacity, then pushes into it and moves end to end.
	task automatic test_full_buffer();
		logic [CHAR_W-1:0] c;
		do_req(REQ_ESCAPE);
		type_key(KEY_APPEND);
		while (head_n + tail_n < CAPACITY) begin
			c = CHAR_W'($urandom_range(1, 255));
			if (c == KEY_BACKSPACE || c == KEY_IGNORED)
				c = 8'h80;
			type_key(c);
		end
		do_req(REQ_LEFT);
		do_req(REQ_LEFT);
		type_key(8'h41);
		type_key(8'hff);
		do_req(REQ_BEGIN);
		type_key(8'h42);
		read_at(9'd0);
		read_at(IDX_W'(CAPACITY - 1));
		read_at(IDX_W'(CAPACITY));
		do_req(REQ_END);
		do_req(REQ_RIGHT);
		type_key(KEY_BACKSPACE);
		do_req(REQ_BEGIN);
		do_req(REQ_FWD_DEL);
	endtask

	// Key choice that follows the current mode, so both modes see real work.
	function automatic logic [CHAR_W-1:0] pick_key();
		logic [CHAR_W-1:0] k;
		k = CHAR_W'($urandom_range(255));
		if (cmd_mode) begin
			case ($urandom_range(7))
				0: k = KEY_CUT;
				1: k = KEY_CUT_PREV;
				2, 3: k = KEY_REPLACE;
				4: k = KEY_APPEND;
				default: ;
			endcase
			// Quit is kept for the last test.
			if (k == KEY_QUIT)
				k = KEY_REPLACE;
		end else begin
			case ($urandom_range(9))
				0: k = KEY_BACKSPACE;
				1: k = KEY_IGNORED;
				default: ;
			endcase
			// Near full, trim often so the length keeps moving.
			if (head_n + tail_n > 192 && $urandom_range(1) == 1)
				k = KEY_BACKSPACE;
		end
		return k;
	endfunction

	task automatic random_mix(int count);
		req_t t;
		logic [CHAR_W-1:0] k;
		logic [IDX_W-1:0] idx;
		int roll;
		for (int n = 0; n < count; n++) begin
			roll = $urandom_range(99);
			k = pick_key();
			if (roll < 45)
				t = REQ_KEY;
			else if (roll < 53)
				t = REQ_RIGHT;
			else if (roll < 61)
				t = REQ_LEFT;
			else if (roll < 64)
				t = REQ_END;
			else if (roll < 67)
				t = REQ_BEGIN;
			else if (roll < 73)
				t = REQ_FWD_DEL;
			else if (roll < 79)
				t = REQ_ESCAPE;
			else
				t = REQ_READ;
			if ($urandom_range(4) == 0)
				idx = IDX_W'($urandom_range(511));
			else
				idx = IDX_W'($urandom_range(head_n + tail_n));
			send_word(t, k, idx);
		end
	endtask

	task automatic test_random_mix();
		set_idling(0, 0);
		random_mix(300);
		set_idling(74, 0);
		random_mix(400);
		set_idling(0, 74);
		random_mix(400);
		set_idling(21, 21);
		random_mix(400);
		set_idling(0, 0);
		random_mix(200);
	endtask

	// Quit: everything but reads is ignored afterwards.
	task automatic test_quit();
		do_req(REQ_ESCAPE);
		do_req(REQ_LEFT);
		type_key(KEY_QUIT);
		do_req(REQ_RIGHT);
		do_req(REQ_LEFT);
		do_req(REQ_END);
		do_req(REQ_BEGIN);
		do_req(REQ_FWD_DEL);
		do_req(REQ_ESCAPE);
		type_key(KEY_APPEND);
		type_key(KEY_CUT);
		read_at(9'd0);
		read_at(IDX_W'(head_n + tail_n - 1));
		read_at(9'd511);
	endtask

	// Reset, tests in turn, then drain and the final verdict.
	initial begin
		arst_n <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.req_type <= REQ_KEY;
		req_ch.key_char <= KEY_NONE;
		req_ch.read_index <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_edit_keys();
		test_read_commands();
		test_full_buffer();
		test_random_mix();
		test_quit();
		req_ch.valid <= 1'b0;
		for (int n = 0; n < 200000 && status_queue.size() != 0; n++)
			@(posedge clk);
		repeat (CAPACITY + 8) @(posedge clk);
		if (status_queue.size() != 0)
			report_mismatch("status words never returned", 0, status_queue.size());
		if (error_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/mgb_pkg.sv
hw/rtl/mgb_req_if.sv
hw/rtl/mgb_rsp_if.sv
hw/rtl/mgb_ctrl.sv
hw/rtl/mgb_dpath.sv
hw/rtl/modal_gap_buffer_line_editor.sv
test/testbench.sv
